// ===== src/srrr_pkg.sv =====
// shared types and constants of the selective-repeat reorder receiver
package srrr_pkg;

  localparam int SEQ_SPACE_DEF   = 256;
  localparam int WINDOW_DEF      = 16;
  localparam int MAX_PAYLOAD_DEF = 1024;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  typedef struct packed {
    logic [7:0]  seq_num;
    logic [10:0] seg_length;
    logic        is_last;
    logic [31:0] payload_ref;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_seq;
    logic [10:0] out_length;
    logic [31:0] out_ref;
    logic [7:0]  ack_num;
    logic        end_of_run;
  } out_word_t;

  // front to back: classified arrival
  typedef struct packed {
    logic        done;     // transfer already ended
    logic        deliver;  // d == 0
    logic        store;    // 0 < d < 2*window
    logic [7:0]  seq;
    logic [10:0] len;
    logic        last;
    logic [31:0] pref;
    logic [7:0]  gap;
  } cmd_t;

endpackage

// ===== src/srrr_front.sv =====
// front end: clips the length and classifies the arriving word by distance
module srrr_front #(
  parameter int WINDOW      = srrr_pkg::WINDOW_DEF,
  parameter int MAX_PAYLOAD = srrr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  srrr_pkg::in_word_t in_word,
  input  logic [7:0]         expected,
  input  logic               done,
  output logic               cmd_valid,
  output srrr_pkg::cmd_t     cmd,
  input  logic               cmd_pop
);

  localparam int          SEQ_SPACE = srrr_pkg::SEQ_SPACE_DEF;
  localparam logic [11:0] DWIN = 12'(2 * WINDOW);
  localparam logic [10:0] MAXL = 11'(MAX_PAYLOAD > 2047 ? 2047 : MAX_PAYLOAD);
  localparam logic [7:0]  MASK = 8'(SEQ_SPACE - 1);

  srrr_pkg::cmd_t cmd_r, cmd_nxt;
  logic           valid_r;
  logic [7:0]     seq, gap;

  always_comb begin
    seq  = in_word.seq_num & MASK;
    gap  = (seq - expected) & MASK;
    cmd_nxt.done    = done;
    cmd_nxt.deliver = (gap == 8'd0);
    cmd_nxt.store   = (gap != 8'd0) && ({4'd0, gap} < DWIN);
    cmd_nxt.seq     = seq;
    cmd_nxt.len     = (in_word.seg_length > MAXL) ? MAXL : in_word.seg_length;
    cmd_nxt.last    = in_word.is_last;
    cmd_nxt.pref    = in_word.payload_ref;
    cmd_nxt.gap     = gap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (cmd_pop) begin
      valid_r <= 1'b0;
    end
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

// ===== src/srrr_back.sv =====
// back end: slot store, in-order drain and ack generation
module srrr_back #(
  parameter int WINDOW    = srrr_pkg::WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  srrr_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic [7:0]          expected,
  output logic                done,
  output logic                out_valid,
  output srrr_pkg::out_word_t out_word
);

  localparam int SEQ_SPACE = srrr_pkg::SEQ_SPACE_DEF;
  localparam logic [7:0] MASK  = 8'(SEQ_SPACE - 1);
  localparam int LIM = (2 * WINDOW < SEQ_SPACE) ? 2 * WINDOW : SEQ_SPACE;
  localparam logic [11:0] LIMV = 12'(LIM);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_ACK, S_FIN} state_t;

  state_t      state_r;
  logic [7:0]  exp_r, head_r;
  logic        done_r;
  logic [11:0] cnt_r;
  logic [255:0] valid_r, last_r;
  logic [50:0] mem [256];
  logic [50:0] rd_r;
  logic [7:0]  slot;
  logic        ov_r;
  srrr_pkg::out_word_t ow_r;

  function automatic srrr_pkg::out_word_t mk_word(logic [1:0] k, logic [7:0] s,
                                                  logic [10:0] l, logic [31:0] p,
                                                  logic [7:0] a, logic e);
    srrr_pkg::out_word_t w;
    w.kind       = k;
    w.out_seq    = s;
    w.out_length = l;
    w.out_ref    = p;
    w.ack_num    = a;
    w.end_of_run = e;
    return w;
  endfunction

  assign slot = (head_r + cmd.gap) & MASK;

  always_ff @(posedge clk) begin
    if (cmd_valid && state_r == S_IDLE && !cmd.done && cmd.store && !valid_r[slot]) begin
      mem[slot] <= {cmd.seq, cmd.len, cmd.pref};
    end
    rd_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      exp_r   <= 8'd0;
      head_r  <= 8'd0;
      done_r  <= 1'b0;
      cnt_r   <= 12'd0;
      valid_r <= '0;
      last_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.done) begin
              ov_r <= 1'b1;
              ow_r <= mk_word(srrr_pkg::KIND_FINAL, 8'd0, 11'd0, 32'd0, exp_r, 1'b1);
            end else if (cmd.deliver) begin
              ov_r <= 1'b1;
              ow_r <= mk_word(srrr_pkg::KIND_DATA, cmd.seq, cmd.len, cmd.pref,
                              8'd0, 1'b0);
              if (cmd.last) begin
                done_r  <= 1'b1;
                state_r <= S_ACK;
              end else begin
                exp_r   <= (exp_r + 8'd1) & MASK;
                head_r  <= (head_r + 8'd1) & MASK;
                cnt_r   <= 12'd1;
                state_r <= S_RD;
              end
            end else begin
              ov_r <= 1'b0;
              if (cmd.store && !valid_r[slot]) begin
                valid_r[slot] <= 1'b1;
                last_r[slot]  <= cmd.last;
              end
              state_r <= S_ACK;
            end
          end else begin
            ov_r <= 1'b0;
          end
        end
        // memory read of head slot in flight
        S_RD: begin
          ov_r    <= 1'b0;
          state_r <= (cnt_r < LIMV && valid_r[head_r]) ? S_CHK : S_ACK;
        end
        S_CHK: begin
          ov_r <= 1'b1;
          ow_r <= mk_word(srrr_pkg::KIND_DATA, rd_r[50:43], rd_r[42:32], rd_r[31:0],
                          8'd0, 1'b0);
          valid_r[head_r] <= 1'b0;
          if (last_r[head_r]) begin
            last_r[head_r] <= 1'b0;
            done_r  <= 1'b1;
            state_r <= S_ACK;
          end else begin
            exp_r   <= (exp_r + 8'd1) & MASK;
            head_r  <= (head_r + 8'd1) & MASK;
            cnt_r   <= cnt_r + 12'd1;
            state_r <= S_RD;
          end
        end
        S_ACK: begin
          ov_r <= 1'b1;
          ow_r <= mk_word(srrr_pkg::KIND_ACK, 8'd0, 11'd0, 32'd0, exp_r, !done_r);
          state_r <= done_r ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          ov_r <= 1'b1;
          ow_r <= mk_word(srrr_pkg::KIND_FINAL, 8'd0, 11'd0, 32'd0, exp_r, 1'b1);
          state_r <= S_IDLE;
        end
        default: begin
          ov_r    <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd_pop   = cmd_valid && state_r == S_IDLE;
  assign expected  = exp_r;
  assign done      = done_r;
  assign out_valid = ov_r;
  assign out_word  = ow_r;

endmodule

// ===== src/selective_repeat_reorder_receiver.sv =====
// top level of the selective-repeat reorder receiver
//
//  channel | ports                        | flow
//  in      | start, busy, in_word         | start && !busy takes a word
//  out     | out_valid, out_word          | one cycle strobe, no back pressure
//
// from one accepted word to the next: an arrival in order is emitted, then each
// drained slot takes a slot memory read then an emit, then the ack and, if the
// transfer ended, the final word follow; a stored or stale word gives the ack; a
// word after the end gives the final word; the drain loop sets the worst case.
// reset is synchronous, active low; slot valid and last flags clear at once.
// busy stays high while a word sits in the front register or the back works.
module selective_repeat_reorder_receiver #(
  parameter int WINDOW      = srrr_pkg::WINDOW_DEF,
  parameter int MAX_PAYLOAD = srrr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  srrr_pkg::in_word_t  in_word,
  output logic                out_valid,
  output srrr_pkg::out_word_t out_word
);

  logic           cmd_valid, cmd_pop, done;
  logic [7:0]     expected;
  srrr_pkg::cmd_t cmd;
  logic           back_busy_r;

  // back is busy from pop until it emits the word that ends its run; the front
  // register is single so classification always sees the settled expected number
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      back_busy_r <= 1'b0;
    end else if (cmd_pop) begin
      back_busy_r <= 1'b1;
    end else if (out_valid && out_word.end_of_run) begin
      back_busy_r <= 1'b0;
    end
  end

  assign busy = cmd_valid || back_busy_r;

  srrr_front #(
    .WINDOW(WINDOW), .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk, .rst_n,
    .take(start && !busy),
    .in_word,
    .expected,
    .done,
    .cmd_valid,
    .cmd,
    .cmd_pop
  );

  srrr_back #(
    .WINDOW(WINDOW)
  ) u_back (
    .clk, .rst_n,
    .cmd_valid,
    .cmd,
    .cmd_pop,
    .expected,
    .done,
    .out_valid,
    .out_word
  );

endmodule

// ===== verif/selective_repeat_reorder_receiver_test.sv =====
// self-checking testbench of the selective-repeat reorder receiver
`timescale 1ns / 1ps

module selective_repeat_reorder_receiver_test;

  localparam int SPACE  = srrr_pkg::SEQ_SPACE_DEF;
  localparam int WIN2   = 2 * srrr_pkg::WINDOW_DEF;
  localparam int MAXLEN = srrr_pkg::MAX_PAYLOAD_DEF;
  // longest quiet stretch: sender gaps plus a full drain, taken many times over
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 2 + 4 * WIN2;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  srrr_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  srrr_pkg::out_word_t out_word;

  selective_repeat_reorder_receiver uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_valid(out_valid), .out_word(out_word)
  );

  always #10 clk = ~clk;

  // words waiting to be sent, and results still owed by the block
  srrr_pkg::in_word_t  send_q[$];
  srrr_pkg::out_word_t owed_q[$];

  // shadow copy of the receive window
  bit          win_valid[SPACE];
  bit          win_last[SPACE];
  logic [7:0]  win_seq[SPACE];
  logic [10:0] win_len[SPACE];
  logic [31:0] win_ref[SPACE];
  logic [7:0]  head_idx;
  logic [7:0]  next_seq;
  bit          finished;

  int errors = 0;
  int idle_pct = 20;
  int quiet = 0;
  bit holding = 1'b0;

  task automatic report(string what, srrr_pkg::out_word_t got,
                        srrr_pkg::out_word_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic srrr_pkg::out_word_t ack_word(logic [1:0] k, logic [7:0] num);
    srrr_pkg::out_word_t r;
    r = '0;
    r.kind = k;
    r.ack_num = num;
    return r;
  endfunction

  function automatic srrr_pkg::out_word_t data_word(logic [7:0] s, logic [10:0] l,
                                                    logic [31:0] p);
    srrr_pkg::out_word_t r;
    r = '0;
    r.kind = srrr_pkg::KIND_DATA;
    r.out_seq = s;
    r.out_length = l;
    r.out_ref = p;
    return r;
  endfunction

  // work out what one accepted word makes the block emit
  task automatic predict_arrival(srrr_pkg::in_word_t w);
    srrr_pkg::out_word_t res[$];
    logic [7:0]  ahead;
    logic [7:0]  s;
    logic [10:0] len;
    len = (w.seg_length > MAXLEN) ? 11'(MAXLEN) : w.seg_length;
    if (finished) begin
      res.push_back(ack_word(srrr_pkg::KIND_FINAL, next_seq));
    end else begin
      ahead = w.seq_num - next_seq;
      if (ahead == 0) begin
        res.push_back(data_word(w.seq_num, len, w.payload_ref));
        if (w.is_last) begin
          finished = 1'b1;
        end else begin
          next_seq++;
          head_idx++;
          // drain buffered words in order, up to the window bound
          for (int k = 1; k < WIN2; k++) begin
            s = head_idx;
            if (!win_valid[s]) break;
            res.push_back(data_word(win_seq[s], win_len[s], win_ref[s]));
            win_valid[s] = 1'b0;
            if (win_last[s]) begin
              win_last[s] = 1'b0;
              finished = 1'b1;
              break;
            end
            next_seq++;
            head_idx++;
          end
        end
      end else if (ahead < WIN2) begin
        s = head_idx + ahead;
        if (!win_valid[s]) begin
          win_valid[s] = 1'b1;
          win_seq[s] = w.seq_num;
          win_len[s] = len;
          win_last[s] = w.is_last;
          win_ref[s] = w.payload_ref;
        end
      end
      res.push_back(ack_word(srrr_pkg::KIND_ACK, next_seq));
      if (finished) res.push_back(ack_word(srrr_pkg::KIND_FINAL, next_seq));
    end
    res[res.size() - 1].end_of_run = 1'b1;
    foreach (res[i]) owed_q.push_back(res[i]);
  endtask

  // queue a word at a given offset from the current expected number
  task automatic queue_word(int ahead, int len, bit last, logic [31:0] pref);
    srrr_pkg::in_word_t w;
    w.seq_num = 8'(next_seq + ahead);
    w.seg_length = 11'(len);
    w.is_last = last;
    w.payload_ref = pref;
    send_q.push_back(w);
  endtask

  task automatic wait_drained();
    while (send_q.size() != 0 || holding || owed_q.size() != 0) @(posedge clk);
  endtask

  // a burst of in-order words in shuffled order, mixed with noise words
  task automatic queue_burst(int k, output int cnt);
    int order[$];
    int j;
    int t;
    cnt = 0;
    for (int i = 0; i < k; i++) order.push_back(i);
    for (int i = k - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) begin
      queue_word(order[i], $urandom_range(2047), 1'b0, $urandom);
      cnt++;
      if ($urandom_range(99) < 25) begin
        case ($urandom_range(2))
          0: queue_word(SPACE - $urandom_range(1, 60), $urandom_range(2047),
                        1'($urandom_range(1)), $urandom);
          1: queue_word($urandom_range(WIN2, SPACE - 61), $urandom_range(2047),
                        1'($urandom_range(1)), $urandom);
          default: queue_word($urandom_range(k - 1), $urandom_range(2047),
                              1'($urandom_range(1)), $urandom);
        endcase
        cnt++;
      end
    end
  endtask

  // driver: new word at the falling edge, held until taken
  always @(negedge clk) begin
    if (!(start && holding)) begin
      if (rst_n && send_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_word <= send_q[0];
        holding = 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // acceptance, checking and watchdog at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      quiet++;
      if (start && !busy && holding) begin
        predict_arrival(in_word);
        void'(send_q.pop_front());
        holding = 1'b0;
        quiet = 0;
      end
      if (out_valid) begin
        quiet = 0;
        if (owed_q.size() == 0) begin
          report("unexpected word", out_word, '0);
        end else begin
          if (out_word.kind !== owed_q[0].kind)
            report("kind", out_word, owed_q[0]);
          else if (out_word.out_seq !== owed_q[0].out_seq)
            report("out_seq", out_word, owed_q[0]);
          else if (out_word.out_length !== owed_q[0].out_length)
            report("out_length", out_word, owed_q[0]);
          else if (out_word.out_ref !== owed_q[0].out_ref)
            report("out_ref", out_word, owed_q[0]);
          else if (out_word.ack_num !== owed_q[0].ack_num)
            report("ack_num", out_word, owed_q[0]);
          else if (out_word.end_of_run !== owed_q[0].end_of_run)
            report("end_of_run", out_word, owed_q[0]);
          void'(owed_q.pop_front());
        end
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("selective_repeat_reorder_receiver_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int n;
    foreach (win_valid[i]) begin
      win_valid[i] = 1'b0;
      win_last[i] = 1'b0;
    end
    head_idx = '0;
    next_seq = '0;
    finished = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes of the fields, clipping, stale, too far, occupied slot
    queue_word(0, 0, 1'b0, 32'h0);
    queue_word(0, 2047, 1'b0, 32'hffff_ffff);
    queue_word(0, MAXLEN, 1'b0, 32'h5555_aaaa);
    wait_drained();
    queue_word(-1, 5, 1'b1, 32'h1);
    queue_word(WIN2, 6, 1'b1, 32'h2);
    queue_word(WIN2 - 1, 7, 1'b0, 32'h3);
    queue_word(WIN2 - 1, 8, 1'b0, 32'h4);
    queue_word(SPACE - 1, 9, 1'b1, 32'h5);
    queue_word(2, 1025, 1'b0, 32'h6);
    queue_word(1, 10, 1'b0, 32'h7);
    queue_word(0, 11, 1'b0, 32'h8);
    wait_drained();
    // longest drain: fill the whole window, then the gap at its front
    for (int i = WIN2 - 1; i >= 1; i--) queue_word(i, i, 1'b0, $urandom);
    queue_word(0, 1, 1'b0, $urandom);
    wait_drained();

    // random bursts; sender idle pattern changes by phase
    sent = 0;
    while (sent < 360) begin
      if (sent < 120) idle_pct = 20;
      else if (sent < 240) idle_pct = 68;
      else idle_pct = 0;
      queue_burst($urandom_range(1, WIN2), n);
      sent += n;
      wait_drained();
    end

    // end of transfer: last word buffered, then the gap filled, then random words
    queue_word(3, 100, 1'b1, $urandom);
    queue_word(2, 200, 1'b0, $urandom);
    queue_word(1, 300, 1'b0, $urandom);
    queue_word(0, 400, 1'b0, $urandom);
    for (int i = 0; i < 8; i++)
      queue_word($urandom_range(SPACE - 1), $urandom_range(2047),
                 1'($urandom_range(1)), $urandom);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && owed_q.size() == 0) begin
      $display("selective_repeat_reorder_receiver_test: PASS");
    end else begin
      $display("selective_repeat_reorder_receiver_test: FAIL");
    end
    $finish;
  end

endmodule
